@@ design/multi_level_priority_ring_queue_unit_defines.svh @@
// ----------------------------------------------------------------------------
// priority ring queue assertion macros
// Assertion wrappers; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MULTI_LEVEL_PRIORITY_RING_QUEUE_UNIT_DEFINES_SVH
`define MULTI_LEVEL_PRIORITY_RING_QUEUE_UNIT_DEFINES_SVH
`ifndef SYNTH
`define PRQ_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("priority ring queue assertion failed");
`define PRQ_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("priority ring queue assertion failed");
`else
`define PRQ_ASSERT(label, clk, rst, prop)
`define PRQ_NEVER(label, clk, rst, expr)
`endif
`endif

@@ design/prq_pkg.sv @@
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types and constants of the multi-level priority ring queue.
// ----------------------------------------------------------------------------
package prq_pkg;

  localparam int DEF_NUM_QUEUES = 8;
  localparam int DEF_MAX_DEPTH  = 16;

  localparam int DATA_W    = 32;
  localparam int LEVEL_W   = 4;
  localparam int COUNT_W   = 4;
  localparam int DEPTH_W   = 5;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam int STATUS_W  = 4;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_DEPTH = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd1;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd16;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK               = 4'd0,
    ST_BAD_LEVEL        = 4'd1,
    ST_ZERO_ELEM        = 4'd2,
    ST_PUSH_NEEDS_LEVEL = 4'd3,
    ST_FIFO_PUSH_LEVEL  = 4'd4,
    ST_FULL             = 4'd5,
    ST_FIFO_POP_LEVEL   = 4'd6,
    ST_ALL_EMPTY        = 4'd7,
    ST_QUEUE_EMPTY      = 4'd8
  } status_t;

  typedef struct packed {
    status_t status;
    logic    pop_ok;
  } result_t;

endpackage

@@ design/prq_mem.sv @@
// ----------------------------------------------------------------------------
// prq_mem
// Slot storage, one row of MAX_DEPTH entries per queue, registered read.
// ----------------------------------------------------------------------------
module prq_mem #(
  parameter int NUM_QUEUES = prq_pkg::DEF_NUM_QUEUES,
  parameter int MAX_DEPTH  = prq_pkg::DEF_MAX_DEPTH,
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
  localparam int PW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [QW-1:0]              wr_q,
  input  logic [PW-1:0]              wr_p,
  input  logic [prq_pkg::DATA_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [QW-1:0]              rd_q,
  input  logic [PW-1:0]              rd_p,
  output logic [prq_pkg::DATA_W-1:0] rd_data
);

  logic [prq_pkg::DATA_W-1:0] slots [NUM_QUEUES][MAX_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_q][wr_p] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= slots[rd_q][rd_p];
    end
  end

endmodule

@@ design/prq_ctrl.sv @@
// ----------------------------------------------------------------------------
// prq_ctrl
// Request decode, queue selection, and per-queue pointers and flags.
// ----------------------------------------------------------------------------
`include "multi_level_priority_ring_queue_unit_defines.svh"

module prq_ctrl #(
  parameter int NUM_QUEUES = prq_pkg::DEF_NUM_QUEUES,
  parameter int MAX_DEPTH  = prq_pkg::DEF_MAX_DEPTH,
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
  localparam int PW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               proc,
  input  logic                               func,
  input  logic signed [prq_pkg::LEVEL_W-1:0] level,
  input  logic signed [prq_pkg::DATA_W-1:0]  item_value,
  input  logic [prq_pkg::COUNT_W-1:0]        queue_count,
  input  logic [prq_pkg::DEPTH_W-1:0]        queue_depth,
  output prq_pkg::result_t                   result,
  output logic                               mem_wr_en,
  output logic [QW-1:0]                      mem_wr_q,
  output logic [PW-1:0]                      mem_wr_p,
  output logic [prq_pkg::DATA_W-1:0]         mem_wr_data,
  output logic                               mem_rd_en,
  output logic [QW-1:0]                      mem_rd_q,
  output logic [PW-1:0]                      mem_rd_p
);

  logic [PW-1:0]         rd_ptr [NUM_QUEUES];
  logic [PW-1:0]         wr_ptr [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] empty;
  logic [NUM_QUEUES-1:0] full;

  logic [prq_pkg::COUNT_W-1:0] eff_cnt;
  logic [prq_pkg::DEPTH_W-1:0] eff_dep;
  logic                        fifo;
  logic                        lvl_default;
  logic [prq_pkg::LEVEL_W-1:0] lvl_u;
  logic                        bad;
  logic [QW-1:0]               lvl_q;
  logic [QW-1:0]               enc_q;
  logic                        found;
  logic [QW-1:0]               q;
  logic                        act;
  prq_pkg::status_t            st;
  logic [PW-1:0]               wr_adv;
  logic [PW-1:0]               rd_adv;

  function automatic logic [PW-1:0] step(input logic [PW-1:0] p,
                                         input logic [prq_pkg::DEPTH_W-1:0] d);
    logic [PW:0] n;
    n = (PW+1)'(p) + (PW+1)'(1);
    if (int'(n) >= int'(d)) begin
      return '0;
    end
    return n[PW-1:0];
  endfunction

  always_comb begin
    if (queue_count == '0) begin
      eff_cnt = prq_pkg::COUNT_W'(1);
    end else if (int'(queue_count) > NUM_QUEUES) begin
      eff_cnt = prq_pkg::COUNT_W'(NUM_QUEUES);
    end else begin
      eff_cnt = queue_count;
    end
    if (queue_depth == '0) begin
      eff_dep = prq_pkg::DEPTH_W'(1);
    end else if (int'(queue_depth) > MAX_DEPTH) begin
      eff_dep = prq_pkg::DEPTH_W'(MAX_DEPTH);
    end else begin
      eff_dep = queue_depth;
    end
  end

  assign fifo        = (eff_cnt == prq_pkg::COUNT_W'(1));
  assign lvl_default = (level == '1);
  assign lvl_u       = {1'b0, level[prq_pkg::LEVEL_W-2:0]};
  // negative levels other than the default marker, or past the queue count
  assign bad   = level[prq_pkg::LEVEL_W-1] ? !lvl_default : (int'(lvl_u) >= int'(eff_cnt));
  assign lvl_q = QW'(lvl_u);

  // lowest-numbered non-empty queue within the count
  always_comb begin
    enc_q = '0;
    found = 1'b0;
    for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
      if (!empty[i] && (i < int'(eff_cnt))) begin
        enc_q = QW'(i);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    st  = prq_pkg::ST_OK;
    q   = '0;
    act = 1'b0;
    if (func == prq_pkg::FUNC_PUSH) begin
      if (bad) begin
        st = prq_pkg::ST_BAD_LEVEL;
      end else if (item_value == '0) begin
        st = prq_pkg::ST_ZERO_ELEM;
      end else if (lvl_default && !fifo) begin
        st = prq_pkg::ST_PUSH_NEEDS_LEVEL;
      end else if (!lvl_default && fifo) begin
        st = prq_pkg::ST_FIFO_PUSH_LEVEL;
      end else begin
        q = lvl_default ? '0 : lvl_q;
        if (full[q]) begin
          st = prq_pkg::ST_FULL;
        end else begin
          act = 1'b1;
        end
      end
    end else begin
      if (bad) begin
        st = prq_pkg::ST_BAD_LEVEL;
      end else if (!lvl_default && fifo) begin
        st = prq_pkg::ST_FIFO_POP_LEVEL;
      end else if (lvl_default && !fifo && !found) begin
        st = prq_pkg::ST_ALL_EMPTY;
      end else begin
        // default pop in fifo mode goes to queue zero
        q = !lvl_default ? lvl_q : (fifo ? '0 : enc_q);
        if (empty[q]) begin
          st = prq_pkg::ST_QUEUE_EMPTY;
        end else begin
          act = 1'b1;
        end
      end
    end
  end

  assign wr_adv = step(wr_ptr[q], eff_dep);
  assign rd_adv = step(rd_ptr[q], eff_dep);

  assign result.status = st;
  assign result.pop_ok = act && (func == prq_pkg::FUNC_POP);

  assign mem_wr_en   = proc && act && (func == prq_pkg::FUNC_PUSH);
  assign mem_wr_q    = q;
  assign mem_wr_p    = wr_ptr[q];
  assign mem_wr_data = item_value;
  assign mem_rd_en   = proc;
  assign mem_rd_q    = q;
  assign mem_rd_p    = rd_ptr[q];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        rd_ptr[i] <= '0;
        wr_ptr[i] <= '0;
      end
      empty <= '1;
      full  <= '0;
    end else if (proc && act) begin
      if (func == prq_pkg::FUNC_PUSH) begin
        wr_ptr[q] <= wr_adv;
        if (wr_adv == rd_ptr[q]) begin
          full[q] <= 1'b1;
        end
        empty[q] <= 1'b0;
      end else begin
        rd_ptr[q] <= rd_adv;
        if (rd_adv == wr_ptr[q]) begin
          empty[q] <= 1'b1;
        end
        // any pop frees a slot, even the one that empties the queue
        full[q] <= 1'b0;
      end
    end
  end

  `PRQ_NEVER(a_full_and_empty, clk, rst, (full & empty) != '0)
  `PRQ_ASSERT(a_push_fills, clk, rst, (proc && act && func == prq_pkg::FUNC_PUSH) |=> !empty[$past(q)])
  `PRQ_ASSERT(a_pop_frees, clk, rst, (proc && act && func == prq_pkg::FUNC_POP) |=> !full[$past(q)])
  `PRQ_ASSERT(a_reject_holds, clk, rst, (proc && !act) |=> ($stable(empty) && $stable(full)))

endmodule

@@ design/multi_level_priority_ring_queue_unit.sv @@
// ----------------------------------------------------------------------------
// multi_level_priority_ring_queue_unit
// Bank of ring-buffer queues, one per priority level, with push/pop requests.
// ----------------------------------------------------------------------------
// Takes one request per clock while req_stall is low and presents one result
// per request: the request is captured in an input register, decoded against
// the queue flags and pointers, and the status plus the slot memory's
// registered read data form the result, held in the result register. The
// single-port-per-side slot memory and the per-queue pointer update set that
// one-request-per-cycle figure. req_stall rises only while a result is held by
// res_stall. The queues come out of reset empty with no clearing pass;
// configuration writes leave queue contents in place.
module multi_level_priority_ring_queue_unit #(
  parameter int NUM_QUEUES = prq_pkg::DEF_NUM_QUEUES,
  parameter int MAX_DEPTH  = prq_pkg::DEF_MAX_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [prq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [prq_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                 req_valid,
  output logic                                 req_stall,
  input  logic                                 func,
  input  logic signed [prq_pkg::LEVEL_W-1:0]   level,
  input  logic signed [prq_pkg::DATA_W-1:0]    item_value,
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output logic [prq_pkg::STATUS_W-1:0]         status,
  output logic signed [prq_pkg::DATA_W-1:0]    popped_value
);

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic [prq_pkg::COUNT_W-1:0] queue_count;
  logic [prq_pkg::DEPTH_W-1:0] queue_depth;

  logic                              in_vld;
  logic                              func_r;
  logic signed [prq_pkg::LEVEL_W-1:0] level_r;
  logic signed [prq_pkg::DATA_W-1:0]  item_r;

  logic                        out_ready;
  logic                        proc;
  prq_pkg::result_t            result;
  prq_pkg::result_t            res;

  logic                        mem_wr_en;
  logic [QW-1:0]               mem_wr_q;
  logic [PW-1:0]               mem_wr_p;
  logic [prq_pkg::DATA_W-1:0]  mem_wr_data;
  logic                        mem_rd_en;
  logic [QW-1:0]               mem_rd_q;
  logic [PW-1:0]               mem_rd_p;
  logic [prq_pkg::DATA_W-1:0]  mem_rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_count <= prq_pkg::COUNT_RESET;
      queue_depth <= prq_pkg::DEPTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        prq_pkg::REG_QUEUE_COUNT: queue_count <= cfg_data[prq_pkg::COUNT_W-1:0];
        prq_pkg::REG_QUEUE_DEPTH: queue_depth <= cfg_data[prq_pkg::DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_ready = !res_valid || !res_stall;
  assign proc      = in_vld && out_ready;
  assign req_stall = in_vld && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (!req_stall) begin
        in_vld <= req_valid;
      end
      if (out_ready) begin
        res_valid <= in_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      func_r  <= func;
      level_r <= level;
      item_r  <= item_value;
    end
    if (proc) begin
      res <= result;
    end
  end

  prq_ctrl #(
    .NUM_QUEUES(NUM_QUEUES),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .proc       (proc),
    .func       (func_r),
    .level      (level_r),
    .item_value (item_r),
    .queue_count(queue_count),
    .queue_depth(queue_depth),
    .result     (result),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_q   (mem_wr_q),
    .mem_wr_p   (mem_wr_p),
    .mem_wr_data(mem_wr_data),
    .mem_rd_en  (mem_rd_en),
    .mem_rd_q   (mem_rd_q),
    .mem_rd_p   (mem_rd_p)
  );

  prq_mem #(
    .NUM_QUEUES(NUM_QUEUES),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_q   (mem_wr_q),
    .wr_p   (mem_wr_p),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_q   (mem_rd_q),
    .rd_p   (mem_rd_p),
    .rd_data(mem_rd_data)
  );

  assign status       = res.status;
  // read data only counts for a successful pop
  assign popped_value = res.pop_ok ? signed'(mem_rd_data) : '0;

endmodule

@@ test/prq_result_checker.sv @@
// ----------------------------------------------------------------------------
// prq_result_checker
// Watches the request, result and register channels of the priority ring
// queue, keeps its own copy of the queue bank, predicts the status and popped
// element of every accepted request and compares them with the results.
// ----------------------------------------------------------------------------
module prq_result_checker
  import prq_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic                       req_valid,
  input  logic                       req_stall,
  input  logic                       func,
  input  logic signed [LEVEL_W-1:0]  level,
  input  logic signed [DATA_W-1:0]   item_value,
  input  logic                       res_valid,
  input  logic                       res_stall,
  input  logic [STATUS_W-1:0]        status,
  input  logic signed [DATA_W-1:0]   popped_value,
  output int                         fail_count,
  output logic                       idle,
  output logic                       drained
);

  localparam int NQ    = DEF_NUM_QUEUES;
  localparam int MD    = DEF_MAX_DEPTH;
  localparam int PTR_W = $clog2(MD);
  localparam int QI_W  = $clog2(NQ);

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] value;
  } outcome_t;

  logic [DATA_W-1:0]  slots [NQ][MD];
  logic [PTR_W-1:0]   rd_ptr [NQ];
  logic [PTR_W-1:0]   wr_ptr [NQ];
  logic               q_empty [NQ];
  logic               q_full [NQ];
  logic [COUNT_W-1:0] count_reg;
  logic [DEPTH_W-1:0] depth_reg;
  outcome_t           outcomes_q [$];
  int                 mismatches = 0;

  assign fail_count = mismatches;

  function automatic int live_queues();
    if (count_reg == '0) return 1;
    if (int'(count_reg) > NQ) return NQ;
    return int'(count_reg);
  endfunction

  function automatic int live_depth();
    if (depth_reg == '0) return 1;
    if (int'(depth_reg) > MD) return MD;
    return int'(depth_reg);
  endfunction

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    int n;
    n = int'(p) + 1;
    return (n >= live_depth()) ? '0 : PTR_W'(n);
  endfunction

  // applies one request to the queue bank and returns its outcome
  function automatic outcome_t predict_request(input logic f,
                                               input logic signed [LEVEL_W-1:0] lv,
                                               input logic [DATA_W-1:0] v);
    outcome_t        o;
    int              cnt;
    int              lvl;
    logic [QI_W-1:0] q;
    logic            fifo;
    logic            found;
    cnt     = live_queues();
    fifo    = (cnt == 1);
    lvl     = int'(lv);
    q       = '0;
    found   = 1'b1;
    o.value = '0;
    if (lvl < -1 || lvl >= cnt) begin
      o.status = ST_BAD_LEVEL;
    end else if (f == FUNC_PUSH) begin
      if (v == '0) o.status = ST_ZERO_ELEM;
      else if (lvl == -1 && !fifo) o.status = ST_PUSH_NEEDS_LEVEL;
      else if (lvl != -1 && fifo) o.status = ST_FIFO_PUSH_LEVEL;
      else begin
        q = (lvl == -1) ? '0 : QI_W'(lvl);
        if (q_full[q]) begin
          o.status = ST_FULL;
        end else begin
          slots[q][wr_ptr[q]] = v;
          wr_ptr[q] = next_slot(wr_ptr[q]);
          if (wr_ptr[q] == rd_ptr[q]) q_full[q] = 1'b1;
          q_empty[q] = 1'b0;
          o.status = ST_OK;
        end
      end
    end else if (lvl != -1 && fifo) begin
      o.status = ST_FIFO_POP_LEVEL;
    end else begin
      if (lvl != -1) begin
        q = QI_W'(lvl);
      end else if (!fifo) begin
        // default pop takes the lowest-numbered queue holding something
        found = 1'b0;
        for (int i = cnt - 1; i >= 0; i--) begin
          if (!q_empty[QI_W'(i)]) begin
            q = QI_W'(i);
            found = 1'b1;
          end
        end
      end
      if (!found) begin
        o.status = ST_ALL_EMPTY;
      end else if (q_empty[q]) begin
        o.status = ST_QUEUE_EMPTY;
      end else begin
        o.value = slots[q][rd_ptr[q]];
        rd_ptr[q] = next_slot(rd_ptr[q]);
        if (rd_ptr[q] == wr_ptr[q]) q_empty[q] = 1'b1;
        q_full[q] = 1'b0;
        o.status = ST_OK;
      end
    end
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    logic     all_empty;
    if (rst) begin
      for (int i = 0; i < NQ; i++) begin
        rd_ptr[QI_W'(i)]  = '0;
        wr_ptr[QI_W'(i)]  = '0;
        q_empty[QI_W'(i)] = 1'b1;
        q_full[QI_W'(i)]  = 1'b0;
      end
      count_reg = COUNT_RESET;
      depth_reg = DEPTH_RESET;
      outcomes_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_QUEUE_COUNT) count_reg = cfg_data[COUNT_W-1:0];
        else depth_reg = cfg_data[DEPTH_W-1:0];
      end
      if (res_valid && !res_stall) begin
        if (outcomes_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: status %0d value %h", status, popped_value);
          mismatches++;
        end else begin
          want = outcomes_q.pop_front();
          if (status !== want.status || popped_value !== want.value) begin
            if (mismatches < 10)
              $display("result mismatch: expected status %0d value %h, got status %0d value %h",
                       want.status, want.value, status, popped_value);
            mismatches++;
          end
        end
      end
      if (req_valid && !req_stall)
        outcomes_q.push_back(predict_request(func, level, item_value));
    end
    all_empty = 1'b1;
    for (int i = 0; i < NQ; i++) begin
      if (!q_empty[QI_W'(i)]) all_empty = 1'b0;
    end
    idle    <= (outcomes_q.size() == 0);
    drained <= all_empty;
  end

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives the priority ring queue with directed and random push/pop requests
// over a range of queue counts and depths, with random idling on both sides
// and long result hold-offs; the checker beside the block scores the results.
// ----------------------------------------------------------------------------
module tb;
  import prq_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SQUEEZE_CYCLES = 80;
  localparam int PHASE_ITEMS    = 80;
  localparam int NUM_PHASES     = 10;

  localparam logic signed [LEVEL_W-1:0] LVL_ANY = -1;

  // count 24 sets the top data bit, which the count register drops
  localparam logic [CFG_W-1:0] COUNT_PLAN [NUM_PHASES] =
    '{5'd1, 5'd8, 5'd3, 5'd0, 5'd24, 5'd15, 5'd2, 5'd5, 5'd1, 5'd8};
  localparam logic [CFG_W-1:0] DEPTH_PLAN [NUM_PHASES] =
    '{5'd16, 5'd16, 5'd4, 5'd0, 5'd1, 5'd31, 5'd7, 5'd3, 5'd2, 5'd16};

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]          cfg_data;
  logic                      req_valid;
  logic                      req_stall;
  logic                      func;
  logic signed [LEVEL_W-1:0] level;
  logic signed [DATA_W-1:0]  item_value;
  logic                      res_valid;
  logic                      res_stall;
  logic [STATUS_W-1:0]       status;
  logic signed [DATA_W-1:0]  popped_value;
  int                        fail_count;
  logic                      idle;
  logic                      drained;

  int   squeeze_cnt = 0;
  int   live_count  = 1;
  int   live_depth  = 16;
  logic steady      = 1'b0;

  multi_level_priority_ring_queue_unit i_dut (.*);

  prq_result_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int clamp_reg(input int v, input int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic send_req(input logic f, input logic signed [LEVEL_W-1:0] lv,
                          input logic [DATA_W-1:0] v);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid  <= 1'b1;
    func       <= f;
    level      <= lv;
    item_value <= v;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (!idle) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(input logic [CFG_W-1:0] cnt_val, input logic [CFG_W-1:0] dep_val);
    int d;
    d = clamp_reg(int'(dep_val), DEF_MAX_DEPTH);
    if (d != live_depth) begin
      // a new depth with entries stored could send a read pointer past the written slots
      write_reg(REG_QUEUE_COUNT, CFG_W'(DEF_NUM_QUEUES));
      while (!drained) send_req(FUNC_POP, LVL_ANY, $urandom);
    end
    write_reg(REG_QUEUE_DEPTH, dep_val);
    write_reg(REG_QUEUE_COUNT, cnt_val);
    live_count = clamp_reg(int'(cnt_val[COUNT_W-1:0]), DEF_NUM_QUEUES);
    live_depth = d;
  endtask

  task automatic random_request(input int push_pct);
    logic                      f;
    logic signed [LEVEL_W-1:0] lv;
    logic [DATA_W-1:0]         v;
    int                        r;
    f = ($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP;
    r = $urandom_range(0, 99);
    if (r < 10) lv = LEVEL_W'($urandom);
    else if (live_count == 1 || (f == FUNC_POP && r < 50) || (f == FUNC_PUSH && r < 15))
      lv = LVL_ANY;
    else lv = LEVEL_W'($urandom_range(0, live_count - 1));
    r = $urandom_range(0, 99);
    if (r < 4) v = '0;
    else if (r < 7) v = 32'h8000_0000;
    else if (r < 10) v = 32'h7fff_ffff;
    else v = $urandom;
    send_req(f, lv, v);
  endtask

  // result side: random stalls, plus a long hold-off when asked
  initial begin : receiver
    int span;
    int seen;
    span = 0;
    seen = 0;
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (span > 0) begin
        span--;
      end else if (squeeze_cnt != seen) begin
        seen++;
        res_stall <= 1'b1;
        span = SQUEEZE_CYCLES;
      end else begin
        res_stall <= ($urandom_range(0, 3) == 0);
        span = idle_len();
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (res_valid && !res_stall)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int push_pct;
    cfg_we     <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    req_valid  <= 1'b0;
    func       <= FUNC_PUSH;
    level      <= '0;
    item_value <= '0;
    rst        <= 1'b1;
    push_pct   = 50;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // fifo mode straight out of reset
    send_req(FUNC_POP, LVL_ANY, 32'h0);          // empty fifo answers queue empty
    send_req(FUNC_POP, 4'sd0, 32'h0);
    send_req(FUNC_PUSH, 4'sd0, 32'h5);
    send_req(FUNC_PUSH, 4'sd3, 32'h5);
    send_req(FUNC_PUSH, -4'sd8, 32'h5);
    send_req(FUNC_POP, -4'sd2, 32'h0);
    send_req(FUNC_PUSH, LVL_ANY, 32'h0);
    send_req(FUNC_PUSH, 4'sd1, 32'h0);           // bad level wins over zero element
    send_req(FUNC_PUSH, LVL_ANY, 32'h8000_0000);
    send_req(FUNC_PUSH, LVL_ANY, 32'h7fff_ffff);
    send_req(FUNC_PUSH, LVL_ANY, 32'hffff_ffff);
    repeat (4) send_req(FUNC_POP, LVL_ANY, $urandom);

    // eight queues, two deep
    write_reg(REG_QUEUE_COUNT, 5'd8);
    write_reg(REG_QUEUE_DEPTH, 5'd2);
    live_count = 8;
    live_depth = 2;
    send_req(FUNC_PUSH, LVL_ANY, 32'h11);
    send_req(FUNC_POP, LVL_ANY, 32'h0);
    send_req(FUNC_POP, 4'sd7, 32'h0);
    send_req(FUNC_PUSH, 4'sd7, 32'hA);
    send_req(FUNC_PUSH, 4'sd7, 32'hB);
    send_req(FUNC_PUSH, 4'sd7, 32'hC);
    send_req(FUNC_PUSH, 4'sd2, 32'hD);
    repeat (3) send_req(FUNC_POP, LVL_ANY, 32'h0);
    send_req(FUNC_POP, 4'sd7, 32'h0);

    // depth one: a pop must clear full even as it empties the queue
    write_reg(REG_QUEUE_DEPTH, 5'd1);
    live_depth = 1;
    send_req(FUNC_PUSH, 4'sd4, 32'h1);
    send_req(FUNC_PUSH, 4'sd4, 32'h2);
    send_req(FUNC_POP, 4'sd4, 32'h0);
    send_req(FUNC_PUSH, 4'sd4, 32'h3);
    send_req(FUNC_POP, LVL_ANY, 32'h0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      apply_setting(COUNT_PLAN[p], DEPTH_PLAN[p]);
      if (p == 1 || p == 8) squeeze_cnt <= squeeze_cnt + 1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 16 == 0) begin
          case ($urandom_range(0, 3))
            0: push_pct = 25;
            1: push_pct = 50;
            2: push_pct = 75;
            default: push_pct = 90;
          endcase
          // keep requests coming back to back while the result side is held off
          steady = ($urandom_range(0, 3) == 0) || (n == 0 && (p == 1 || p == 8));
        end
        random_request(push_pct);
      end
      steady = 1'b0;
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && idle) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
